>>> hdl/psi_pkg.sv
// Shared types and constants for the point-in-simplex test unit.
package psi_pkg;

    localparam int VERTICES   = 1024;
    localparam int VID_W      = $clog2(VERTICES);
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int MIN_W      = PROD_W + 1;
    localparam int P2_W       = DIFF_W + MIN_W;
    localparam int SUM_W      = P2_W + 2;
    localparam int DET_N      = 5;
    localparam int DET_LAT    = 5;  // register stages in psi_det3

    localparam logic [1:0] DIM_NONE     = 2'd0;
    localparam logic [1:0] DIM_INTERVAL = 2'd1;
    localparam logic [1:0] DIM_TRIANGLE = 2'd2;
    localparam logic [1:0] DIM_TETRA    = 2'd3;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    // sign of one determinant
    typedef struct packed {
        logic pos;
        logic neg;
    } t_sign;

endpackage

>>> hdl/psi_det3.sv
// Five-stage pipelined sign of the 3x3 orientation determinant of (a-d, b-d, c-d).
module psi_det3 (
    input  logic          i_clk,
    input  psi_pkg::t_vec i_a,
    input  psi_pkg::t_vec i_b,
    input  psi_pkg::t_vec i_c,
    input  psi_pkg::t_vec i_d,
    output psi_pkg::t_sign o_sign
);
    typedef logic signed [psi_pkg::DIFF_W-1:0] t_diff;
    typedef logic signed [psi_pkg::PROD_W-1:0] t_prod;
    typedef logic signed [psi_pkg::MIN_W-1:0]  t_min;
    typedef logic signed [psi_pkg::P2_W-1:0]   t_p2;
    typedef logic signed [psi_pkg::SUM_W-1:0]  t_sum;

    // stage 1: differences
    t_diff r_adx, r_ady, r_adz, r_bdx, r_bdy, r_bdz, r_cdx, r_cdy, r_cdz;
    // stage 2: minor products
    t_prod r_q0, r_q1, r_q2, r_q3, r_q4, r_q5;
    t_diff r_adx2, r_bdx2, r_cdx2;
    // stage 3: minors
    t_min  r_m0, r_m1, r_m2;
    t_diff r_adx3, r_bdx3, r_cdx3;
    // stage 4: cofactor products
    t_p2   r_t0, r_t1, r_t2;
    t_sum  n_sum;

    always_ff @(posedge i_clk) begin
        r_adx <= t_diff'(i_a.x) - t_diff'(i_d.x);
        r_ady <= t_diff'(i_a.y) - t_diff'(i_d.y);
        r_adz <= t_diff'(i_a.z) - t_diff'(i_d.z);
        r_bdx <= t_diff'(i_b.x) - t_diff'(i_d.x);
        r_bdy <= t_diff'(i_b.y) - t_diff'(i_d.y);
        r_bdz <= t_diff'(i_b.z) - t_diff'(i_d.z);
        r_cdx <= t_diff'(i_c.x) - t_diff'(i_d.x);
        r_cdy <= t_diff'(i_c.y) - t_diff'(i_d.y);
        r_cdz <= t_diff'(i_c.z) - t_diff'(i_d.z);

        r_q0   <= t_prod'(r_bdy) * t_prod'(r_cdz);
        r_q1   <= t_prod'(r_bdz) * t_prod'(r_cdy);
        r_q2   <= t_prod'(r_cdy) * t_prod'(r_adz);
        r_q3   <= t_prod'(r_cdz) * t_prod'(r_ady);
        r_q4   <= t_prod'(r_ady) * t_prod'(r_bdz);
        r_q5   <= t_prod'(r_adz) * t_prod'(r_bdy);
        r_adx2 <= r_adx;
        r_bdx2 <= r_bdx;
        r_cdx2 <= r_cdx;

        r_m0   <= t_min'(r_q0) - t_min'(r_q1);
        r_m1   <= t_min'(r_q2) - t_min'(r_q3);
        r_m2   <= t_min'(r_q4) - t_min'(r_q5);
        r_adx3 <= r_adx2;
        r_bdx3 <= r_bdx2;
        r_cdx3 <= r_cdx2;

        r_t0 <= t_p2'(r_adx3) * t_p2'(r_m0);
        r_t1 <= t_p2'(r_bdx3) * t_p2'(r_m1);
        r_t2 <= t_p2'(r_cdx3) * t_p2'(r_m2);

        o_sign.pos <= !n_sum[psi_pkg::SUM_W-1] && (n_sum != '0);
        o_sign.neg <= n_sum[psi_pkg::SUM_W-1];
    end

    assign n_sum = t_sum'(r_t0) + t_sum'(r_t1) + t_sum'(r_t2);

endmodule

>>> hdl/point_in_simplex_test_unit.sv
// Top level: vertex store, corner fetch and containment decision pipeline.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------
//  request  | start / busy            | i_req_type, i_vertex_id, i_coord_x/y/z,
//           |                         | i_corner0..i_corner3
//  result   | o_valid (one-cycle)     | o_inside_res, o_flat_cell
//  config   | i_cfg_we                | i_cfg_wdata (dimension)
//
// A load word does not raise busy and gives no result. A query word holds busy
// while the remaining corners are fetched, so a new query waits for the fetch:
// the single port of the vertex store reads one corner per cycle. The result
// strobe is registered after the launch stage and determinant pipe, in which queries
// overlap. Reset clears control state and sets the dimension to triangle; the store
// keeps no reset. The receiver cannot stall, so the pipe advances every cycle.
module point_in_simplex_test_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_req_type,
    input  logic [psi_pkg::VID_W-1:0]  i_vertex_id,
    input  psi_pkg::t_coord            i_coord_x,
    input  psi_pkg::t_coord            i_coord_y,
    input  psi_pkg::t_coord            i_coord_z,
    input  logic [psi_pkg::VID_W-1:0]  i_corner0,
    input  logic [psi_pkg::VID_W-1:0]  i_corner1,
    input  logic [psi_pkg::VID_W-1:0]  i_corner2,
    input  logic [psi_pkg::VID_W-1:0]  i_corner3,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_wdata,
    output logic                       o_valid,
    output logic                       o_inside_res,
    output logic                       o_flat_cell
);
    logic [1:0]                 r_dimension;

    // vertex store
    logic [$bits(psi_pkg::t_vec)-1:0] r_mem [psi_pkg::VERTICES];
    psi_pkg::t_vec              r_rdata;
    logic [psi_pkg::VID_W-1:0]  n_addr;
    logic                       n_we;
    logic                       n_rd;
    psi_pkg::t_vec              n_wvec;

    // corner fetch
    logic                       r_fetch;
    logic [1:0]                 r_cnt;
    logic                       r_rd_vld;
    logic [1:0]                 r_rd_idx;
    logic [psi_pkg::VID_W-1:0]  r_corner [1:3];
    psi_pkg::t_vec              r_pt;
    psi_pkg::t_vec              r_p [0:2];
    logic                       n_accept;
    logic                       n_launch;

    // launch stage
    logic                       r_a_vld;
    logic [1:0]                 r_a_dim;
    psi_pkg::t_vec              r_a_p [0:3];
    psi_pkg::t_vec              r_a_pt;

    // determinant inputs and outputs
    psi_pkg::t_vec              n_da [psi_pkg::DET_N];
    psi_pkg::t_vec              n_db [psi_pkg::DET_N];
    psi_pkg::t_vec              n_dc [psi_pkg::DET_N];
    psi_pkg::t_vec              n_dd [psi_pkg::DET_N];
    psi_pkg::t_sign             w_sign [psi_pkg::DET_N];

    // side information travelling beside the determinants
    logic [psi_pkg::DET_LAT-1:0] r_vld_pipe;
    logic [1:0]                 r_dim_pipe [psi_pkg::DET_LAT];
    logic [3:0]                 r_rng_pipe [psi_pkg::DET_LAT];
    logic [3:0]                 n_rng;
    logic                       n_inside;
    logic                       n_flat;

    assign busy     = r_fetch;
    assign n_accept = start && !busy;
    assign n_launch = r_rd_vld && (r_rd_idx == 2'd3);

    // dimension register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension <= psi_pkg::DIM_TRIANGLE;
        end else if (i_cfg_we) begin
            r_dimension <= i_cfg_wdata;
        end
    end

    // store address: accepted word first, then the remaining corners
    always_comb begin
        n_wvec = '{x: i_coord_x, y: i_coord_y, z: i_coord_z};
        n_we   = n_accept && (i_req_type == psi_pkg::REQ_LOAD);
        n_rd   = 1'b0;
        n_addr = i_vertex_id;
        if (n_accept && (i_req_type == psi_pkg::REQ_QUERY)) begin
            n_addr = i_corner0;
            n_rd   = 1'b1;
        end else if (r_fetch) begin
            n_addr = r_corner[r_cnt];
            n_rd   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_addr] <= n_wvec;
        end
        r_rdata <= r_mem[n_addr];
    end

    // fetch sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch  <= 1'b0;
            r_cnt    <= 2'd0;
            r_rd_vld <= 1'b0;
            r_rd_idx <= 2'd0;
        end else begin
            r_rd_vld <= n_rd;
            if (n_accept && (i_req_type == psi_pkg::REQ_QUERY)) begin
                r_fetch  <= 1'b1;
                r_cnt    <= 2'd1;
                r_rd_idx <= 2'd0;
            end else if (r_fetch) begin
                r_rd_idx <= r_cnt;
                r_cnt    <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_fetch <= 1'b0;
                end
            end
        end
    end

    // hold the query payload and the corners read so far
    always_ff @(posedge i_clk) begin
        if (n_accept && (i_req_type == psi_pkg::REQ_QUERY)) begin
            r_pt        <= n_wvec;
            r_corner[1] <= i_corner1;
            r_corner[2] <= i_corner2;
            r_corner[3] <= i_corner3;
        end
        if (r_rd_vld && (r_rd_idx != 2'd3)) begin
            r_p[r_rd_idx] <= r_rdata;
        end
    end

    // launch stage: all four corners present
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= n_launch;
        end
        if (n_launch) begin
            r_a_p[0] <= r_p[0];
            r_a_p[1] <= r_p[1];
            r_a_p[2] <= r_p[2];
            r_a_p[3] <= r_rdata;
            r_a_pt   <= r_pt;
            r_a_dim  <= r_dimension;
        end
    end

    // Map the tests onto the determinant units. A 2D orientation of (a, b, c)
    // is the 3D determinant of (a,0), (b,0), (c,1) against (c,0).
    always_comb begin
        for (int k = 0; k < psi_pkg::DET_N; k++) begin
            n_da[k] = '0;
            n_db[k] = '0;
            n_dc[k] = '0;
            n_dd[k] = '0;
        end
        if (r_a_dim == psi_pkg::DIM_TETRA) begin
            n_da[0] = r_a_p[0]; n_db[0] = r_a_p[1]; n_dc[0] = r_a_p[2]; n_dd[0] = r_a_p[3];
            n_da[1] = r_a_p[0]; n_db[1] = r_a_p[1]; n_dc[1] = r_a_p[2]; n_dd[1] = r_a_pt;
            n_da[2] = r_a_p[0]; n_db[2] = r_a_p[3]; n_dc[2] = r_a_p[1]; n_dd[2] = r_a_pt;
            n_da[3] = r_a_p[0]; n_db[3] = r_a_p[2]; n_dc[3] = r_a_p[3]; n_dd[3] = r_a_pt;
            n_da[4] = r_a_p[1]; n_db[4] = r_a_p[3]; n_dc[4] = r_a_p[2]; n_dd[4] = r_a_pt;
        end else begin
            // reference: (p0, p1, p2)
            n_da[0] = '{x: r_a_p[0].x, y: r_a_p[0].y, z: '0};
            n_db[0] = '{x: r_a_p[1].x, y: r_a_p[1].y, z: '0};
            n_dc[0] = '{x: r_a_p[2].x, y: r_a_p[2].y, z: psi_pkg::t_coord'(1)};
            n_dd[0] = '{x: r_a_p[2].x, y: r_a_p[2].y, z: '0};
            // (p1, p2, pt)
            n_da[1] = '{x: r_a_p[1].x, y: r_a_p[1].y, z: '0};
            n_db[1] = '{x: r_a_p[2].x, y: r_a_p[2].y, z: '0};
            n_dc[1] = '{x: r_a_pt.x, y: r_a_pt.y, z: psi_pkg::t_coord'(1)};
            n_dd[1] = '{x: r_a_pt.x, y: r_a_pt.y, z: '0};
            // (p2, p0, pt)
            n_da[2] = '{x: r_a_p[2].x, y: r_a_p[2].y, z: '0};
            n_db[2] = '{x: r_a_p[0].x, y: r_a_p[0].y, z: '0};
            n_dc[2] = '{x: r_a_pt.x, y: r_a_pt.y, z: psi_pkg::t_coord'(1)};
            n_dd[2] = '{x: r_a_pt.x, y: r_a_pt.y, z: '0};
            // (p0, p1, pt)
            n_da[3] = '{x: r_a_p[0].x, y: r_a_p[0].y, z: '0};
            n_db[3] = '{x: r_a_p[1].x, y: r_a_p[1].y, z: '0};
            n_dc[3] = '{x: r_a_pt.x, y: r_a_pt.y, z: psi_pkg::t_coord'(1)};
            n_dd[3] = '{x: r_a_pt.x, y: r_a_pt.y, z: '0};
        end
    end

    for (genvar g = 0; g < psi_pkg::DET_N; g++) begin : g_det
        psi_det3 u_det (
            .i_clk  (i_clk),
            .i_a    (n_da[g]),
            .i_b    (n_db[g]),
            .i_c    (n_dc[g]),
            .i_d    (n_dd[g]),
            .o_sign (w_sign[g])
        );
    end

    function automatic logic in_rng(input psi_pkg::t_coord a, input psi_pkg::t_coord b,
                                    input psi_pkg::t_coord v);
        if (a > b) begin
            return (b <= v) && (v <= a);
        end
        return (a <= v) && (v <= b);
    endfunction

    // bounding-box checks: [0] interval p0-p1 on x, [1] edge p0-p1,
    // [2] edge p1-p2, [3] edge p2-p0
    always_comb begin
        n_rng[0] = in_rng(r_a_p[0].x, r_a_p[1].x, r_a_pt.x);
        n_rng[1] = n_rng[0] && in_rng(r_a_p[0].y, r_a_p[1].y, r_a_pt.y);
        n_rng[2] = in_rng(r_a_p[1].x, r_a_p[2].x, r_a_pt.x)
                && in_rng(r_a_p[1].y, r_a_p[2].y, r_a_pt.y);
        n_rng[3] = in_rng(r_a_p[2].x, r_a_p[0].x, r_a_pt.x)
                && in_rng(r_a_p[2].y, r_a_p[0].y, r_a_pt.y);
    end

    // carry valid, dimension and range bits alongside the determinant pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pipe <= '0;
        end else begin
            r_vld_pipe <= {r_vld_pipe[psi_pkg::DET_LAT-2:0], r_a_vld};
        end
        r_dim_pipe[0] <= r_a_dim;
        r_rng_pipe[0] <= n_rng;
        for (int k = 1; k < psi_pkg::DET_LAT; k++) begin
            r_dim_pipe[k] <= r_dim_pipe[k-1];
            r_rng_pipe[k] <= r_rng_pipe[k-1];
        end
    end

    // decision
    always_comb begin
        n_inside = 1'b0;
        n_flat   = 1'b0;
        case (r_dim_pipe[psi_pkg::DET_LAT-1])
            psi_pkg::DIM_NONE: begin
                n_inside = 1'b0;
            end
            psi_pkg::DIM_INTERVAL: begin
                n_inside = r_rng_pipe[psi_pkg::DET_LAT-1][0];
            end
            psi_pkg::DIM_TRIANGLE: begin
                if (w_sign[0].pos) begin
                    n_inside = !w_sign[1].neg && !w_sign[2].neg && !w_sign[3].neg;
                end else if (w_sign[0].neg) begin
                    n_inside = !w_sign[1].pos && !w_sign[2].pos && !w_sign[3].pos;
                end else begin
                    // collinear triangle: on any edge segment
                    n_inside =
                        (!w_sign[3].pos && !w_sign[3].neg
                            && r_rng_pipe[psi_pkg::DET_LAT-1][1]) ||
                        (!w_sign[1].pos && !w_sign[1].neg
                            && r_rng_pipe[psi_pkg::DET_LAT-1][2]) ||
                        (!w_sign[2].pos && !w_sign[2].neg
                            && r_rng_pipe[psi_pkg::DET_LAT-1][3]);
                end
            end
            psi_pkg::DIM_TETRA: begin
                if (w_sign[0].pos) begin
                    n_inside = !w_sign[1].neg && !w_sign[2].neg
                            && !w_sign[3].neg && !w_sign[4].neg;
                end else if (w_sign[0].neg) begin
                    n_inside = !w_sign[1].pos && !w_sign[2].pos
                            && !w_sign[3].pos && !w_sign[4].pos;
                end else begin
                    n_flat = 1'b1;
                end
            end
            default: begin
                n_inside = 1'b0;
            end
        endcase
    end

    // result register: one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid      <= 1'b0;
            o_inside_res <= 1'b0;
            o_flat_cell  <= 1'b0;
        end else begin
            o_valid      <= r_vld_pipe[psi_pkg::DET_LAT-1];
            o_inside_res <= r_vld_pipe[psi_pkg::DET_LAT-1] && n_inside;
            o_flat_cell  <= r_vld_pipe[psi_pkg::DET_LAT-1] && n_flat;
        end
    end

endmodule

>>> hdl/psi_checker.sv
// Port-level checks for the point-in-simplex test unit, bound to the top level.
module psi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_req_type,
    input logic o_valid,
    input logic o_inside_res,
    input logic o_flat_cell
);
    // a flat cell never reports containment
    a_flat_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_flat_cell |-> !o_inside_res)
        else $error("flat cell with inside set");

    // result fields stay low between strobes
    a_idle_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> (!o_inside_res && !o_flat_cell))
        else $error("result field set without strobe");

    // reset drops the strobe
    a_rst_strobe: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("strobe after reset");

    // an accepted query raises busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type) |=> busy)
        else $error("query did not raise busy");

    // busy drops once the corner fetch ends
    a_busy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy) && $past(busy, 2)) |=> !busy)
        else $error("busy held too long");

endmodule

bind point_in_simplex_test_unit psi_checker u_psi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_req_type   (i_req_type),
    .o_valid      (o_valid),
    .o_inside_res (o_inside_res),
    .o_flat_cell  (o_flat_cell)
);

>>> tb/sv/point_in_simplex_test_unit_tb.sv
// Self-checking testbench for the point-in-simplex containment test unit.
module point_in_simplex_test_unit_tb;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 16;   // lets the last result strobe leave the pipe
    localparam string MSG_PASS = "PASS point_in_simplex_test_unit";
    localparam string MSG_FAIL = "FAIL point_in_simplex_test_unit";

    typedef struct {
        longint x;
        longint y;
        longint z;
    } pnt_t;

    typedef struct {
        logic hit;
        logic flat;
    } verdict_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_req_type = psi_pkg::REQ_LOAD;
    logic [9:0]        i_vertex_id = '0;
    logic signed [15:0] i_coord_x = '0;
    logic signed [15:0] i_coord_y = '0;
    logic signed [15:0] i_coord_z = '0;
    logic [9:0]        i_corner0 = '0;
    logic [9:0]        i_corner1 = '0;
    logic [9:0]        i_corner2 = '0;
    logic [9:0]        i_corner3 = '0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_wdata = psi_pkg::DIM_TRIANGLE;
    logic              o_valid;
    logic              o_inside_res;
    logic              o_flat_cell;

    // predictor state: a shadow of the vertex store and of the dimension register
    pnt_t       mesh_coords [psi_pkg::VERTICES];
    bit         mesh_loaded [psi_pkg::VERTICES];
    int         loaded_ids[$];
    logic [1:0] mesh_dim = psi_pkg::DIM_TRIANGLE;
    verdict_t   expected_verdicts[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;

    point_in_simplex_test_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_vertex_id  (i_vertex_id),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_corner0    (i_corner0),
        .i_corner1    (i_corner1),
        .i_corner2    (i_corner2),
        .i_corner3    (i_corner3),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_inside_res (o_inside_res),
        .o_flat_cell  (o_flat_cell)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: no correct run comes near this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display(MSG_FAIL);
            $finish;
        end
    end

    function automatic int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic int orient_2d(pnt_t a, pnt_t b, pnt_t c);
        return sign_of((a.x - c.x) * (b.y - c.y) - (a.y - c.y) * (b.x - c.x));
    endfunction

    function automatic int orient_3d(pnt_t a, pnt_t b, pnt_t c, pnt_t d);
        longint adx, ady, adz, bdx, bdy, bdz, cdx, cdy, cdz;
        adx = a.x - d.x; ady = a.y - d.y; adz = a.z - d.z;
        bdx = b.x - d.x; bdy = b.y - d.y; bdz = b.z - d.z;
        cdx = c.x - d.x; cdy = c.y - d.y; cdz = c.z - d.z;
        return sign_of(adx * (bdy * cdz - bdz * cdy) + bdx * (cdy * adz - cdz * ady)
                       + cdx * (ady * bdz - adz * bdy));
    endfunction

    function automatic bit between(longint a, longint b, longint v);
        return (a > b) ? (b <= v && v <= a) : (a <= v && v <= b);
    endfunction

    function automatic bit on_edge(pnt_t a, pnt_t b, pnt_t p);
        return orient_2d(a, b, p) == 0 && between(a.x, b.x, p.x) && between(a.y, b.y, p.y);
    endfunction

    // Containment verdict for one query against the shadow store.
    function automatic verdict_t predict_containment(pnt_t p, int c0, int c1, int c2, int c3);
        verdict_t v;
        pnt_t a, b, c, d;
        int   o, s0, s1, s2, s3;
        a = mesh_coords[c0]; b = mesh_coords[c1];
        c = mesh_coords[c2]; d = mesh_coords[c3];
        v.hit  = 1'b0;
        v.flat = 1'b0;
        case (mesh_dim)
            psi_pkg::DIM_INTERVAL: begin
                v.hit = between(a.x, b.x, p.x);
            end
            psi_pkg::DIM_TRIANGLE: begin
                o  = orient_2d(a, b, c);
                s0 = orient_2d(b, c, p);
                s1 = orient_2d(c, a, p);
                s2 = orient_2d(a, b, p);
                if (o > 0)
                    v.hit = s0 >= 0 && s1 >= 0 && s2 >= 0;
                else if (o < 0)
                    v.hit = s0 <= 0 && s1 <= 0 && s2 <= 0;
                else
                    v.hit = on_edge(a, b, p) || on_edge(b, c, p) || on_edge(c, a, p);
            end
            psi_pkg::DIM_TETRA: begin
                o  = orient_3d(a, b, c, d);
                s0 = orient_3d(a, b, c, p);
                s1 = orient_3d(a, d, b, p);
                s2 = orient_3d(a, c, d, p);
                s3 = orient_3d(b, d, c, p);
                if (o > 0)
                    v.hit = s0 >= 0 && s1 >= 0 && s2 >= 0 && s3 >= 0;
                else if (o < 0)
                    v.hit = s0 <= 0 && s1 <= 0 && s2 <= 0 && s3 <= 0;
                else
                    v.flat = 1'b1;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string what, logic got, logic want);
        $display("mismatch at cycle %0d: %s got %0b expected %0b", cycle_count, what, got, want);
        error_count++;
    endtask

    // Check every result strobe against the oldest expected verdict.
    always @(posedge i_clk) begin
        verdict_t want;
        if (i_rst_n && o_valid) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected result word", o_valid, 1'b0);
            end else begin
                want = expected_verdicts.pop_front();
                if (o_inside_res !== want.hit)
                    report_mismatch("inside_res", o_inside_res, want.hit);
                if (o_flat_cell !== want.flat)
                    report_mismatch("flat_cell", o_flat_cell, want.flat);
            end
        end
    end

    // Send one word; return just after the edge that accepts it, start left high.
    task automatic send_word(logic req, int vid, int x, int y, int z,
                             int c0, int c1, int c2, int c3);
        pnt_t p;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_req_type  <= req;
        i_vertex_id <= vid[9:0];
        i_coord_x   <= x[15:0];
        i_coord_y   <= y[15:0];
        i_coord_z   <= z[15:0];
        i_corner0   <= c0[9:0];
        i_corner1   <= c1[9:0];
        i_corner2   <= c2[9:0];
        i_corner3   <= c3[9:0];
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        // the shadow store keeps coordinates already wrapped to 16 bits
        p.x = longint'($signed(x[15:0]));
        p.y = longint'($signed(y[15:0]));
        p.z = longint'($signed(z[15:0]));
        if (req == psi_pkg::REQ_LOAD) begin
            mesh_coords[vid[9:0]] = p;
            if (!mesh_loaded[vid[9:0]]) begin
                mesh_loaded[vid[9:0]] = 1'b1;
                loaded_ids.push_back(vid[9:0]);
            end
        end else begin
            expected_verdicts.push_back(predict_containment(p, c0[9:0], c1[9:0],
                                                            c2[9:0], c3[9:0]));
        end
    endtask

    task automatic load_vertex(int vid, int x, int y, int z);
        send_word(psi_pkg::REQ_LOAD, vid, x, y, z, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic query_point(int x, int y, int z, int c0, int c1, int c2, int c3);
        send_word(psi_pkg::REQ_QUERY, $urandom, x, y, z, c0, c1, c2, c3);
    endtask

    // Hold the sender until every expected word has arrived.
    task automatic drain_results();
        start <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the dimension register with the pipe empty.
    task automatic set_dimension(logic [1:0] dim);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= dim;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mesh_dim     = dim;
    endtask

    // Extremes of the coordinates, every dimension and each degenerate cell.
    task automatic test_directed_cells();
        set_dimension(psi_pkg::DIM_TRIANGLE);
        load_vertex(0, 0, 0, 0);
        load_vertex(1, 100, 0, 0);
        load_vertex(2, 0, 100, 0);
        load_vertex(3, 0, 0, 100);
        load_vertex(1023, 32767, 32767, 32767);
        load_vertex(4, -32768, -32768, -32768);
        load_vertex(5, 50, 50, 0);
        load_vertex(6, 0, 0, 0);
        query_point(10, 10, 0, 0, 1, 2, 0);      // inside, anticlockwise
        query_point(50, 50, 0, 0, 1, 2, 0);      // on an edge
        query_point(10, 10, 0, 0, 2, 1, 0);      // inside, clockwise
        query_point(200, 200, 0, 0, 1, 2, 0);    // outside
        query_point(25, 75, 0, 1, 5, 2, 0);      // collinear triangle, on segment
        query_point(0, 0, 0, 1, 5, 2, 0);        // collinear triangle, off segment
        query_point(0, 0, 0, 0, 6, 0, 0);        // point triangle, same point
        query_point(1, 0, 0, 0, 6, 0, 0);        // point triangle, other point
        query_point(0, 0, 0, 4, 1023, 1, 0);     // extreme triangle
        set_dimension(psi_pkg::DIM_TETRA);
        query_point(10, 10, 10, 0, 1, 2, 3);
        query_point(100, 100, 100, 0, 1, 2, 3);
        query_point(1, 1, 0, 0, 1, 2, 5);        // flat tetrahedron
        query_point(-32768, 32767, 0, 4, 1023, 2, 3);
        set_dimension(psi_pkg::DIM_INTERVAL);
        query_point(-32768, 0, 0, 4, 1023, 0, 0);
        query_point(101, 0, 0, 1, 0, 0, 0);
        set_dimension(psi_pkg::DIM_NONE);
        query_point(0, 0, 0, 0, 1, 2, 3);
    endtask

    function automatic int pick_loaded();
        return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
    endfunction

    // Mostly small cells with points near their centre, some noise at full range.
    task automatic test_random_mix(int words);
        int   c[4], n, sel, k;
        longint sx, sy, sz;
        for (int i = 0; i < words; i++) begin
            sel = $urandom_range(0, 99);
            if (i == words / 2)
                drain_results();
            if (sel < 30) begin
                if (sel < 18)
                    load_vertex($urandom_range(0, 1023), $urandom_range(0, 400) - 200,
                                $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
                else if (sel < 24) begin
                    // midpoint of two loaded vertices makes collinear and flat cells
                    c[0] = pick_loaded(); c[1] = pick_loaded();
                    load_vertex($urandom_range(0, 1023),
                                int'((mesh_coords[c[0]].x + mesh_coords[c[1]].x) / 2),
                                int'((mesh_coords[c[0]].y + mesh_coords[c[1]].y) / 2),
                                int'((mesh_coords[c[0]].z + mesh_coords[c[1]].z) / 2));
                end else
                    load_vertex($urandom_range(0, 1023), $urandom, $urandom, $urandom);
            end else begin
                for (k = 0; k < 4; k++)
                    c[k] = pick_loaded();
                n  = (mesh_dim == psi_pkg::DIM_INTERVAL) ? 2 :
                     ((mesh_dim == psi_pkg::DIM_TETRA) ? 4 : 3);
                sx = 0; sy = 0; sz = 0;
                for (k = 0; k < n; k++) begin
                    sx += mesh_coords[c[k]].x;
                    sy += mesh_coords[c[k]].y;
                    sz += mesh_coords[c[k]].z;
                end
                if (sel < 90)
                    query_point(int'(sx / n) + int'($urandom_range(0, 40)) - 20,
                                int'(sy / n) + int'($urandom_range(0, 40)) - 20,
                                int'(sz / n) + int'($urandom_range(0, 40)) - 20,
                                c[0], c[1], c[2], c[3]);
                else if (sel < 95)
                    // land exactly on a corner
                    query_point(int'(mesh_coords[c[1]].x), int'(mesh_coords[c[1]].y),
                                int'(mesh_coords[c[1]].z), c[0], c[1], c[2], c[3]);
                else
                    query_point($urandom, $urandom, $urandom, c[0], c[1], c[2], c[3]);
            end
        end
    endtask

    // Sweep the dimension through all settings under three sender idle rates.
    task automatic test_random_phases();
        logic [1:0] dims[4];
        dims = '{psi_pkg::DIM_TETRA, psi_pkg::DIM_INTERVAL, psi_pkg::DIM_TRIANGLE,
                 psi_pkg::DIM_NONE};
        for (int phase = 0; phase < 12; phase++) begin
            send_idle_pct = (phase < 4) ? 7 : ((phase < 8) ? 79 : 0);
            set_dimension(dims[phase % 4]);
            test_random_mix(115);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 7;
        test_directed_cells();
        test_random_phases();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_verdicts.size() == 0)
            $display(MSG_PASS);
        else
            $display(MSG_FAIL);
        $finish;
    end

endmodule
